// File: hdl/lin_frame_assembler_assert.svh
// assertion macros shared by the lin frame assembler modules
`ifndef LIN_FRAME_ASSEMBLER_ASSERT_SVH
`define LIN_FRAME_ASSEMBLER_ASSERT_SVH

// condition holds at every edge out of reset
`define LFA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define LFA_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define LFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/lfa_pkg.sv
// shared types, constants and helper functions of the lin frame assembler
`timescale 1ns / 1ps
`default_nettype none

package lfa_pkg;

    // frame limits
    localparam int MAX_DATA_BYTES = 8;
    localparam int CNT_W          = 4;

    // token encoding
    localparam logic       TOKEN_BREAK = 1'b0;
    localparam logic       TOKEN_BYTE  = 1'b1;
    localparam logic [7:0] SYNC_BYTE   = 8'h55;

    // command queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // one classified item: which tokens to send and their bytes
    typedef struct packed {
        logic       hdr;       // send break, sync and protected id
        logic [7:0] pid;
        logic       has_data;  // send the data byte
        logic [7:0] data;
        logic       has_ck;    // send the checksum, closing the frame
        logic [7:0] ck;
    } lfa_cmd_t;

    // protected identifier: id with parity p0 in bit 6 and p1 in bit 7
    function automatic logic [7:0] protect_id(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

    // end-around-carry add: a carry out wraps back into bit 0
    function automatic logic [7:0] fold_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8] ? (s[7:0] + 8'd1) : s[7:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/lfa_front.sv
// front end: accepts input beats, tracks the frame and classifies each beat
`timescale 1ns / 1ps
`default_nettype none
`include "lin_frame_assembler_assert.svh"

module lfa_front
    import lfa_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [5:0] frame_id,
    input  wire logic       enhanced,
    input  wire logic       no_data,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    input  wire logic       q_full,
    output logic            push,
    output lfa_cmd_t        cmd
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DATA_BYTES);

    logic             in_frame_reg, in_frame_next;
    logic [7:0]       sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [7:0]       pid;
    logic [7:0]       base_sum;
    logic [7:0]       add_sum;
    logic [CNT_W-1:0] add_cnt;
    logic             closing;

    // handshake: take a beat whenever the queue has room
    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    // sum and count after this beat's data byte
    assign pid      = protect_id(frame_id);
    assign base_sum = in_frame_reg ? sum_reg : (enhanced ? pid : 8'd0);
    assign add_sum  = fold_add(base_sum, data_byte);
    assign add_cnt  = (in_frame_reg ? cnt_reg : '0) + CNT_W'(1);

    // classify the beat
    always_comb begin
        cmd.hdr      = !in_frame_reg;
        cmd.pid      = pid;
        cmd.has_data = 1'b1;
        cmd.data     = data_byte;
        cmd.has_ck   = 1'b0;
        cmd.ck       = ~add_sum;
        closing      = 1'b0;
        if (!in_frame_reg && no_data) begin
            // empty frame: header then checksum
            cmd.has_data = 1'b0;
            cmd.has_ck   = 1'b1;
            cmd.ck       = ~base_sum;
            closing      = 1'b1;
        end else if (last_byte || add_cnt >= MAX_CNT) begin
            cmd.has_ck = 1'b1;
            closing    = 1'b1;
        end
    end

    // frame state update
    always_comb begin
        in_frame_next = in_frame_reg;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        if (push) begin
            if (closing) begin
                in_frame_next = 1'b0;
                sum_next      = 8'd0;
                cnt_next      = '0;
            end else begin
                in_frame_next = 1'b1;
                sum_next      = add_sum;
                cnt_next      = add_cnt;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            sum_reg      <= 8'd0;
            cnt_reg      <= '0;
        end else begin
            in_frame_reg <= in_frame_next;
            sum_reg      <= sum_next;
            cnt_reg      <= cnt_next;
        end
    end

    `LFA_ASSERT_IMPLY(a_open_count, in_frame_reg, (cnt_reg != '0) && (cnt_reg < MAX_CNT), "count out of range inside a frame")
    `LFA_ASSERT_IMPLY(a_idle_clear, !in_frame_reg, (cnt_reg == '0) && (sum_reg == 8'd0), "idle state not cleared")
    `LFA_ASSERT_NEXT(a_close_idle, push && cmd.has_ck, !in_frame_reg, "frame still open after checksum")

endmodule

`default_nettype wire

// File: hdl/lfa_queue.sv
// short command queue between the front end and the token sequencer
`timescale 1ns / 1ps
`default_nettype none
`include "lin_frame_assembler_assert.svh"

module lfa_queue
    import lfa_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire lfa_cmd_t push_cmd,
    input  wire logic     pop,
    output lfa_cmd_t      head,
    output logic          full,
    output logic          empty
);

    localparam logic [QCNT_W-1:0] DEPTH_CNT = QCNT_W'(QUEUE_DEPTH);

    lfa_cmd_t          mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full  = (count_reg == DEPTH_CNT);
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    `LFA_ASSERT_ALWAYS(a_no_overflow, !(push && full), "push into full queue")
    `LFA_ASSERT_ALWAYS(a_no_underflow, !(pop && empty), "pop from empty queue")
    `LFA_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + QCNT_W'(1), "fill count did not advance")

endmodule

`default_nettype wire

// File: hdl/lfa_back.sv
// back end: walks each command through its tokens into the output register
`timescale 1ns / 1ps
`default_nettype none
`include "lin_frame_assembler_assert.svh"

module lfa_back
    import lfa_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire lfa_cmd_t head,
    input  wire logic     q_empty,
    output logic          pop,
    output logic          m_valid,
    input  wire logic     m_ready,
    output logic          token_kind,
    output logic [7:0]    tx_byte,
    output logic          frame_end
);

    typedef enum logic [2:0] {
        PH_BREAK,
        PH_SYNC,
        PH_PID,
        PH_DATA,
        PH_CKSUM
    } phase_t;

    phase_t     phase_reg;
    logic       mid_reg;
    logic       out_vld_reg;
    logic       kind_reg;
    logic [7:0] byte_reg;
    logic       end_reg;

    phase_t     first_ph;
    phase_t     cur_ph;
    phase_t     phase_next;
    logic       tok_kind;
    logic [7:0] tok_byte;
    logic       tok_end;
    logic       done;
    logic       load;

    // token of the head command to send now
    always_comb begin
        if (head.hdr) begin
            first_ph = PH_BREAK;
        end else if (head.has_data) begin
            first_ph = PH_DATA;
        end else begin
            first_ph = PH_CKSUM;
        end
        cur_ph = mid_reg ? phase_reg : first_ph;
    end

    always_comb begin
        tok_kind   = TOKEN_BYTE;
        tok_byte   = 8'd0;
        tok_end    = 1'b0;
        done       = 1'b0;
        phase_next = PH_BREAK;
        case (cur_ph)
            PH_BREAK: begin
                tok_kind   = TOKEN_BREAK;
                phase_next = PH_SYNC;
            end
            PH_SYNC: begin
                tok_byte   = SYNC_BYTE;
                phase_next = PH_PID;
            end
            PH_PID: begin
                tok_byte   = head.pid;
                phase_next = head.has_data ? PH_DATA : PH_CKSUM;
            end
            PH_DATA: begin
                tok_byte   = head.data;
                done       = !head.has_ck;
                phase_next = PH_CKSUM;
            end
            PH_CKSUM: begin
                tok_byte = head.ck;
                tok_end  = 1'b1;
                done     = 1'b1;
            end
            default: begin
                done = 1'b1;
            end
        endcase
    end

    // advance when a command waits and the output register frees up
    assign load = !q_empty && (!out_vld_reg || m_ready);
    assign pop  = load && done;

    // sequencer state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_BREAK;
            mid_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (load) begin
                phase_reg <= phase_next;
                mid_reg   <= !done;
                kind_reg  <= tok_kind;
                byte_reg  <= tok_byte;
                end_reg   <= tok_end;
            end
            out_vld_reg <= load || (out_vld_reg && !m_ready);
        end
    end

    assign m_valid    = out_vld_reg;
    assign token_kind = kind_reg;
    assign tx_byte    = byte_reg;
    assign frame_end  = end_reg;

    `LFA_ASSERT_IMPLY(a_mid_has_cmd, mid_reg, !q_empty, "command left the queue mid-sequence")
    `LFA_ASSERT_NEXT(a_break_sync, load && (cur_ph == PH_BREAK), mid_reg && (phase_reg == PH_SYNC), "sync does not follow break")
    `LFA_ASSERT_IMPLY(a_end_is_byte, out_vld_reg && end_reg, kind_reg == TOKEN_BYTE, "checksum beat marked as break")

endmodule

`default_nettype wire

// File: hdl/lin_frame_assembler.sv
// top level of the lin frame assembler: front end, command queue, token sequencer
//
// Turns input beats into the token stream of LIN frames. The first beat of a frame
// produces a break token (m_axis_tuser low), the sync byte 0x55 and the protected
// identifier, then its data byte; every data byte adds into an end-around-carry sum
// (with the protected identifier as the seed in enhanced mode), and the beat marked
// last, the eighth data byte of a frame, or a first beat with no_data set is followed
// by the inverted sum as the checksum beat with m_axis_tlast high. The front end
// takes one input beat per cycle while its four-entry command queue has room; the
// sequencer sends one token per cycle while m_axis_tready does not stall it. An item
// has one or two tokens for a data beat, four or five for the first beat of a frame.
// The sustained rate is set by that single output token per cycle. Each item passes
// first through the command queue, written when its beat is accepted, and then
// through the output register, which the sequencer loads token by token.
`timescale 1ns / 1ps
`default_nettype none

module lin_frame_assembler
    import lfa_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input beats
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // frame_id[5:0], enhanced[6], data_byte[14:7]
    input  wire logic        s_axis_tuser,   // no_data
    input  wire logic        s_axis_tlast,   // last_byte
    // token beats
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // tx_byte[7:0]
    output logic             m_axis_tuser,   // token_kind
    output logic             m_axis_tlast    // frame_end
);

    logic     push;
    lfa_cmd_t push_cmd;
    lfa_cmd_t head;
    logic     q_full;
    logic     q_empty;
    logic     pop;

    // classify input beats
    lfa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .frame_id  (s_axis_tdata[5:0]),
        .enhanced  (s_axis_tdata[6]),
        .no_data   (s_axis_tuser),
        .data_byte (s_axis_tdata[14:7]),
        .last_byte (s_axis_tlast),
        .q_full    (q_full),
        .push      (push),
        .cmd       (push_cmd)
    );

    // decouple front and back
    lfa_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // emit tokens
    lfa_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .q_empty    (q_empty),
        .pop        (pop),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .token_kind (m_axis_tuser),
        .tx_byte    (m_axis_tdata),
        .frame_end  (m_axis_tlast)
    );

endmodule

`default_nettype wire
